// ----- rtl/pcfg_pkg.sv -----
// Shared types and constants for the type-0 configuration space block.
// Holds stream widths, register dword indexes, identity values and event codes.
// No dependencies.
package pcfg_pkg;

  // Default size of the BAR0 window as log2 bytes.
  localparam int unsigned BAR_SIZE_LOG2_DEF = 24;

  // Stream payload widths: fields packed from bit 0 up, padded to whole bytes.
  localparam int unsigned ADDR_W      = 64;
  localparam int unsigned SIZE_W      = 2;
  localparam int unsigned DATA_W      = 64;
  localparam int unsigned EVENT_W     = 2;
  localparam int unsigned IN_FIELDS_W = ADDR_W + SIZE_W + DATA_W;
  localparam int unsigned IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W = DATA_W + EVENT_W + ADDR_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Request kinds carried on tuser.
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Access size codes.
  localparam logic [1:0] SIZE_1B = 2'd0;
  localparam logic [1:0] SIZE_2B = 2'd1;
  localparam logic [1:0] SIZE_4B = 2'd2;
  localparam logic [1:0] SIZE_8B = 2'd3;

  // Dword indexes (register offset divided by four).
  localparam logic [9:0] REG_ID        = 10'h000;
  localparam logic [9:0] REG_COMMAND   = 10'h001;
  localparam logic [9:0] REG_CLASS_REV = 10'h002;
  localparam logic [9:0] REG_BAR0_LO   = 10'h004;
  localparam logic [9:0] REG_BAR0_HI   = 10'h005;
  localparam logic [9:0] REG_SUBSYS    = 10'h00B;
  localparam logic [9:0] REG_INTR      = 10'h00F;

  // Fixed read values.
  localparam logic [31:0] ID_DWORD        = 32'h0010_1B36;
  localparam logic [31:0] CLASS_REV_DWORD = 32'h0108_0202;
  localparam logic [31:0] BAR_TYPE_BITS   = 32'h0000_0004;
  localparam logic [31:0] BAR_LOW_KEEP    = 32'hFFFF_FFF0;
  localparam logic [31:0] INTR_PIN_DWORD  = 32'h0000_0100;
  localparam logic [7:0]  IRQ_LINE_RESET  = 8'hFF;
  localparam int unsigned CMD_MEM_ENABLE_BIT = 1;

  typedef enum logic [1:0] {
    BarEvNone  = 2'd0,
    BarEvMap   = 2'd1,
    BarEvUnmap = 2'd2
  } bar_event_e;

endpackage

// ----- rtl/pcie_type0_config_space.sv -----
// Type-0 configuration space of function 0 on bus 0 behind an ECAM window.
// Depends on pcfg_pkg for widths, register indexes, fixed values and event codes.
//
// This block answers configuration reads and writes of one PCIe function
// (bus 0, device 0, function 0) as seen through a memory-mapped ECAM window
// whose base is set through the cfg_we_i / cfg_wdata_i port; the user must do so
// only while the block is idle, which it does not enforce. Each request transfer
// carries one read or write of 1, 2, 4 or 8 bytes (8 acts as a full dword) and
// produces exactly one result transfer holding the read data, a BAR0 map/unmap
// event and the BAR0 base for a map event. Any other bus, device or function
// reads as all ones and ignores writes. Only the command register, both BAR0
// dwords and the interrupt line are writable; BAR0 reads back size-masked with
// its type bits so software can size it. A request is held in the input
// register and is resolved on the way into the result register. The block
// takes one transfer every cycle; a stalled output only holds the input side
// once both registers are full. The register state is updated at the edge
// where a request moves into the result register, so back-to-back accesses
// see each other's writes in order. There is no clearing pass after reset.
module pcie_type0_config_space #(
  parameter int unsigned BarSizeLog2 = pcfg_pkg::BAR_SIZE_LOG2_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration: ECAM window base.
  input  logic                            cfg_we_i,
  input  logic [pcfg_pkg::ADDR_W-1:0]     cfg_wdata_i,
  // Request stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: access_address[63:0], size_code[65:64], write_value[129:66], zero pad.
  input  logic [pcfg_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // tuser: req_type[0] (0 read, 1 write).
  input  logic                            s_axis_tuser,
  // Result stream.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: read_value[63:0], bar_event[65:64], map_addr[129:66], zero pad.
  output logic [pcfg_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import pcfg_pkg::*;

  // Address bits of BAR0 above the window size; low bits read as zero.
  localparam logic [31:0] AddrMask = ~((32'd1 << BarSizeLog2) - 32'd1);
  localparam logic [63:0] SpanMask = {32'd0, ~AddrMask};

  // ECAM base register.
  logic [ADDR_W-1:0] ecam_base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ecam_base_q <= '0;
    end else if (cfg_we_i) begin
      ecam_base_q <= cfg_wdata_i;
    end
  end

  // Input register stage.
  logic              in_valid_q;
  logic              in_write_q;
  logic [ADDR_W-1:0] in_addr_q;
  logic [SIZE_W-1:0] in_size_q;
  logic [DATA_W-1:0] in_wdata_q;

  // Result register stage.
  logic              out_valid_q;
  logic [DATA_W-1:0] out_read_q;
  bar_event_e        out_event_q;
  logic [ADDR_W-1:0] out_base_q;

  logic out_free;
  logic advance;
  logic in_take;

  // The result register frees up when empty or when its transfer completes;
  // the input register moves forward whenever the result register is free.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_write_q <= s_axis_tuser;
      in_addr_q  <= s_axis_tdata[ADDR_W-1:0];
      in_size_q  <= s_axis_tdata[ADDR_W+SIZE_W-1:ADDR_W];
      in_wdata_q <= s_axis_tdata[IN_FIELDS_W-1:ADDR_W+SIZE_W];
    end
  end

  // Function registers.
  logic [15:0] command_q, command_d;
  logic [31:0] bar_lo_q, bar_lo_d;
  logic [31:0] bar_hi_q, bar_hi_d;
  logic [7:0]  irq_line_q, irq_line_d;
  logic        bar_mapped_q, bar_mapped_d;

  // Address decode of the request in the input register.
  logic [ADDR_W-1:0] offset;
  logic              absent;
  logic [9:0]        reg_idx;
  logic [4:0]        bit_shift;
  logic [31:0]       cur_dword;
  logic [31:0]       size_mask;
  logic [31:0]       byte_mask;
  logic [31:0]       shifted_data;
  logic [31:0]       merged;
  logic              remap_req;
  logic [63:0]       bar_addr;
  logic              want_map;
  logic [DATA_W-1:0] read_d;
  bar_event_e        event_d;
  logic [ADDR_W-1:0] base_d;

  assign offset    = in_addr_q - ecam_base_q;
  assign absent    = (offset[27:12] != 16'd0);
  assign reg_idx   = offset[11:2];
  assign bit_shift = {offset[1:0], 3'b000};

  always_comb begin
    case (reg_idx)
      REG_ID:        cur_dword = ID_DWORD;
      REG_COMMAND:   cur_dword = {16'd0, command_q};
      REG_CLASS_REV: cur_dword = CLASS_REV_DWORD;
      REG_BAR0_LO:   cur_dword = (bar_lo_q & AddrMask) | BAR_TYPE_BITS;
      REG_BAR0_HI:   cur_dword = bar_hi_q;
      REG_SUBSYS:    cur_dword = ID_DWORD;
      REG_INTR:      cur_dword = INTR_PIN_DWORD | {24'd0, irq_line_q};
      default:       cur_dword = 32'd0;
    endcase
  end

  always_comb begin
    case (in_size_q)
      SIZE_1B: size_mask = 32'h0000_00FF;
      SIZE_2B: size_mask = 32'h0000_FFFF;
      SIZE_4B: size_mask = 32'hFFFF_FFFF;
      SIZE_8B: size_mask = 32'hFFFF_FFFF;
      default: size_mask = 32'hFFFF_FFFF;
    endcase
  end

  // Narrow writes drop bytes that fall past the dword; wide writes take all.
  assign byte_mask    = (in_size_q == SIZE_4B || in_size_q == SIZE_8B) ?
                        32'hFFFF_FFFF : (size_mask << bit_shift);
  assign shifted_data = in_wdata_q[31:0] << bit_shift;
  assign merged       = (cur_dword & ~byte_mask) | (shifted_data & byte_mask);

  always_comb begin
    command_d  = command_q;
    bar_lo_d   = bar_lo_q;
    bar_hi_d   = bar_hi_q;
    irq_line_d = irq_line_q;
    remap_req  = 1'b0;
    if (advance && in_write_q == REQ_WRITE && !absent) begin
      case (reg_idx)
        REG_COMMAND: begin
          command_d = merged[15:0];
          remap_req = 1'b1;
        end
        REG_BAR0_LO: begin
          bar_lo_d  = merged & BAR_LOW_KEEP;
          remap_req = 1'b1;
        end
        REG_BAR0_HI: begin
          bar_hi_d  = merged;
          remap_req = 1'b1;
        end
        REG_INTR: begin
          irq_line_d = merged[7:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Mapping decision on the updated register values.
  assign bar_addr = {bar_hi_d, bar_lo_d & AddrMask};
  assign want_map = command_d[CMD_MEM_ENABLE_BIT] && (bar_addr != 64'd0) &&
                    (bar_addr != {32'd0, AddrMask}) && ((bar_addr & SpanMask) == 64'd0);

  always_comb begin
    bar_mapped_d = bar_mapped_q;
    event_d      = BarEvNone;
    base_d       = '0;
    if (remap_req) begin
      if (want_map && !bar_mapped_q) begin
        bar_mapped_d = 1'b1;
        event_d      = BarEvMap;
        base_d       = bar_addr;
      end else if (!want_map && bar_mapped_q) begin
        bar_mapped_d = 1'b0;
        event_d      = BarEvUnmap;
      end
    end
  end

  always_comb begin
    if (absent) begin
      read_d = (in_write_q == REQ_WRITE) ? '0 : '1;
    end else if (in_write_q == REQ_WRITE) begin
      read_d = '0;
    end else begin
      read_d = {32'd0, (cur_dword >> bit_shift) & size_mask};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      command_q    <= 16'd0;
      bar_lo_q     <= 32'd0;
      bar_hi_q     <= 32'd0;
      irq_line_q   <= IRQ_LINE_RESET;
      bar_mapped_q <= 1'b0;
    end else begin
      command_q    <= command_d;
      bar_lo_q     <= bar_lo_d;
      bar_hi_q     <= bar_hi_d;
      irq_line_q   <= irq_line_d;
      bar_mapped_q <= bar_mapped_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_read_q  <= read_d;
      out_event_q <= event_d;
      out_base_q  <= base_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                          out_base_q, out_event_q, out_read_q};

  // A new mapping is always reported with the map event of the same request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(bar_mapped_q) |-> (out_valid_q && out_event_q == BarEvMap))
    else $error("BAR0 mapped without a map event");

  // Removing the mapping is always reported with an unmap event.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(bar_mapped_q) |-> (out_valid_q && out_event_q == BarEvUnmap))
    else $error("BAR0 unmapped without an unmap event");

  // Events only come from writes, which return zero read data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_event_q != BarEvNone) |-> (out_read_q == '0))
    else $error("BAR0 event on a read result");

  // A map event carries a nonzero, window-aligned base.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_event_q == BarEvMap) |->
      (out_base_q != '0 && (out_base_q & SpanMask) == '0))
    else $error("BAR0 map event with an invalid base");

endmodule

// ----- dv/pcie_type0_config_space_test.sv -----
`timescale 1ns / 100ps
// Self-checking stream testbench for the type-0 configuration space block.
// Depends on pcfg_pkg and pcie_type0_config_space from the rtl folder.
module pcie_type0_config_space_test;
  import pcfg_pkg::*;

  localparam int unsigned BarLog2 = BAR_SIZE_LOG2_DEF;
  localparam logic [31:0] BarAddrMask = ~((32'd1 << BarLog2) - 32'd1);
  localparam int unsigned PadIn = IN_TDATA_W - IN_FIELDS_W;
  localparam int unsigned PhaseItems = 75;

  // One configuration access as it travels on the request stream.
  typedef struct packed {
    logic        kind;       // REQ_READ or REQ_WRITE
    logic [63:0] addr;
    logic [1:0]  size_code;
    logic [63:0] wdata;
  } cfg_access_t;

  // One completion as it travels on the result stream.
  typedef struct packed {
    logic [63:0] rdata;
    bar_event_e  bar_ev;
    logic [63:0] map_addr;
  } cfg_completion_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [ADDR_W-1:0]      cfg_wdata_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  pcie_type0_config_space #(
    .BarSizeLog2(BarLog2)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the function's registers, kept in step with accepted requests.
  logic [63:0] window_base = '0;
  logic [15:0] shadow_cmd;
  logic [31:0] shadow_bar_lo;
  logic [31:0] shadow_bar_hi;
  logic [7:0]  shadow_irq_line;
  logic        shadow_mapped;

  cfg_access_t     access_backlog[$];
  cfg_completion_t due_completions[$];

  // Handshake pacing. quiet_mode turns off all random idling for a phase;
  // rx_hold is the long receiver hold-off that backs the block up.
  logic        quiet_mode = 1'b0;
  logic        rx_hold = 1'b0;
  cfg_access_t offer = '0;
  logic        offering = 1'b0;
  int unsigned tx_gap = 0;
  int unsigned rx_stall = 0;

  int unsigned n_accepted = 0;
  int unsigned n_completed = 0;
  int unsigned n_reads = 0;
  int unsigned n_writes = 0;
  int unsigned n_absent = 0;
  int unsigned n_maps = 0;
  int unsigned n_unmaps = 0;
  int unsigned n_bases = 0;
  int unsigned n_errors = 0;

  logic [9:0] hot_regs [7] = '{REG_ID, REG_COMMAND, REG_CLASS_REV, REG_BAR0_LO,
                               REG_BAR0_HI, REG_SUBSYS, REG_INTR};

  task automatic flag_error(input string what);
    n_errors++;
    if (n_errors <= 10) begin
      $display("%0t ERROR: %s", $realtime, what);
    end
  endtask

  // Value of a register dword as software would read it.
  function automatic logic [31:0] dword_value(input logic [9:0] dw);
    case (dw)
      REG_ID, REG_SUBSYS: return ID_DWORD;
      REG_COMMAND:        return {16'h0000, shadow_cmd};
      REG_CLASS_REV:      return CLASS_REV_DWORD;
      REG_BAR0_LO:        return (shadow_bar_lo & BarAddrMask) | BAR_TYPE_BITS;
      REG_BAR0_HI:        return shadow_bar_hi;
      REG_INTR:           return INTR_PIN_DWORD | {24'h0, shadow_irq_line};
      default:            return 32'h0;
    endcase
  endfunction

  // Re-evaluates whether BAR0 should be decoded after a command or BAR write.
  function automatic void update_bar_mapping(inout cfg_completion_t c);
    logic [63:0] bar_addr;
    logic        wanted;
    bar_addr = {shadow_bar_hi, shadow_bar_lo & BarAddrMask};
    wanted = shadow_cmd[CMD_MEM_ENABLE_BIT] && (bar_addr != 64'h0) &&
             (bar_addr != {32'h0, BarAddrMask}) &&
             ((bar_addr & {32'h0, ~BarAddrMask}) == 64'h0);
    if (wanted && !shadow_mapped) begin
      shadow_mapped = 1'b1;
      c.bar_ev = BarEvMap;
      c.map_addr = bar_addr;
      n_maps++;
    end else if (!wanted && shadow_mapped) begin
      shadow_mapped = 1'b0;
      c.bar_ev = BarEvUnmap;
      n_unmaps++;
    end
  endfunction

  // Applies one access to the shadow registers and returns its completion.
  function automatic cfg_completion_t apply_access(input cfg_access_t a);
    cfg_completion_t c;
    logic [63:0] off;
    logic [9:0]  dw;
    logic [5:0]  sh;
    logic [31:0] lane_mask;
    logic [31:0] merged;
    logic [63:0] data_sh;
    c = '{rdata: 64'h0, bar_ev: BarEvNone, map_addr: 64'h0};
    off = a.addr - window_base;
    dw = off[11:2];
    sh = {off[1:0], 3'b000};
    case (a.size_code)
      SIZE_1B: lane_mask = 32'h0000_00FF;
      SIZE_2B: lane_mask = 32'h0000_FFFF;
      default: lane_mask = 32'hFFFF_FFFF;
    endcase
    if (a.kind == REQ_WRITE) n_writes++;
    else n_reads++;
    if (off[27:12] != 16'h0000) begin
      // Absent function: reads float high, writes vanish.
      n_absent++;
      if (a.kind == REQ_READ) c.rdata = '1;
    end else if (a.kind == REQ_READ) begin
      c.rdata = {32'h0, (dword_value(dw) >> sh) & lane_mask};
    end else begin
      // Narrow lanes shift up and drop whatever falls past the dword.
      if (a.size_code == SIZE_1B || a.size_code == SIZE_2B) lane_mask = lane_mask << sh;
      data_sh = a.wdata << sh;
      merged = (dword_value(dw) & ~lane_mask) | (data_sh[31:0] & lane_mask);
      case (dw)
        REG_COMMAND: begin
          shadow_cmd = merged[15:0];
          update_bar_mapping(c);
        end
        REG_BAR0_LO: begin
          shadow_bar_lo = merged & BAR_LOW_KEEP;
          update_bar_mapping(c);
        end
        REG_BAR0_HI: begin
          shadow_bar_hi = merged;
          update_bar_mapping(c);
        end
        REG_INTR: shadow_irq_line = merged[7:0];
        default: ;
      endcase
    end
    return c;
  endfunction

  // Request driver: offers the backlog in order, with random idle gaps unless quiet.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        due_completions.push_back(apply_access(offer));
        n_accepted++;
        offering = 1'b0;
        tx_gap = quiet_mode ? 0 : $urandom_range(0, 14);
      end
      if (!offering) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (access_backlog.size() > 0) begin
          offer = access_backlog.pop_front();
          offering = 1'b1;
        end
      end
      s_axis_tvalid <= offering;
      s_axis_tuser <= offer.kind;
      s_axis_tdata <= {{PadIn{1'b0}}, offer.wdata, offer.size_code, offer.addr};
    end
  end

  // Result monitor: compares each completion transfer with the oldest one due.
  always @(posedge clk_i) begin
    cfg_completion_t got;
    cfg_completion_t exp;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.rdata = m_axis_tdata[63:0];
        got.bar_ev = bar_event_e'(m_axis_tdata[65:64]);
        got.map_addr = m_axis_tdata[129:66];
        n_completed++;
        if (due_completions.size() == 0) begin
          flag_error($sformatf("completion with none due: %h", got));
        end else begin
          exp = due_completions.pop_front();
          if (got.rdata !== exp.rdata)
            flag_error($sformatf("read_value: expected %h, got %h", exp.rdata, got.rdata));
          if (got.bar_ev !== exp.bar_ev)
            flag_error($sformatf("bar_event: expected %0d, got %0d", exp.bar_ev, got.bar_ev));
          if (got.map_addr !== exp.map_addr)
            flag_error($sformatf("map_addr: expected %h, got %h", exp.map_addr,
                                 got.map_addr));
        end
        rx_stall = quiet_mode ? 0 : $urandom_range(0, 14);
      end else if (rx_stall > 0) begin
        rx_stall--;
      end
      m_axis_tready <= (rx_stall == 0) && !rx_hold;
    end
  end

  // Once the random part is under way the receiver stops for a long stretch,
  // so the block fills both stages and has to push back on the sender.
  initial begin
    wait (n_accepted >= 130);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (300) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("pcie_type0_config_space_test: done, errors");
    $finish;
  end

  function automatic logic [63:0] cfg_off(input logic [15:0] bdf, input logic [9:0] dw,
                                          input logic [1:0] bo);
    return {36'h0, bdf, dw, bo};
  endfunction

  task automatic queue_access(input logic kind, input logic [63:0] off,
                              input logic [1:0] size_code, input logic [63:0] wdata);
    access_backlog.push_back('{kind: kind, addr: window_base + off,
                               size_code: size_code, wdata: wdata});
  endtask

  // Random access: mostly the live function's interesting dwords, some stray
  // dwords and some absent functions. Address bits above the bus field are
  // don't-care to the block and are randomized.
  task automatic queue_random_access();
    logic [63:0] off;
    logic [63:0] wdata;
    int unsigned pick;
    off = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 15) off[27:12] = 16'($urandom_range(1, 16'hFFFF));
    else off[27:12] = 16'h0000;
    if (pick >= 15 && pick < 85) off[11:2] = hot_regs[$urandom_range(0, 6)];
    wdata = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: wdata = 64'h0;
      1: wdata = '1;
      2: wdata[15:0] = 16'h0002 << $urandom_range(0, 1);
      3: wdata[31:0] = wdata[31:0] & BarAddrMask;
      default: ;
    endcase
    queue_access(1'($urandom_range(0, 1)), off, 2'($urandom_range(0, 3)), wdata);
  endtask

  // The usual BAR sizing dance: probe, read back, program, enable decode.
  task automatic queue_bar_sizing();
    queue_access(REQ_WRITE, cfg_off(16'h0, REG_BAR0_LO, 2'd0), SIZE_4B, 64'hFFFF_FFFF);
    queue_access(REQ_READ, cfg_off(16'h0, REG_BAR0_LO, 2'd0), SIZE_4B, 64'h0);
    queue_access(REQ_WRITE, cfg_off(16'h0, REG_BAR0_LO, 2'd0), SIZE_4B,
                 {$urandom, $urandom & BarAddrMask});
    queue_access(REQ_WRITE, cfg_off(16'h0, REG_BAR0_HI, 2'd0), SIZE_4B,
                 ($urandom_range(0, 1) == 0) ? 64'h0 : {$urandom, $urandom});
    queue_access(REQ_WRITE, cfg_off(16'h0, REG_COMMAND, 2'd0), SIZE_2B, 64'h0006);
  endtask

  task automatic wait_idle();
    while (access_backlog.size() != 0 || offering || due_completions.size() != 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Reprograms the window base while nothing is in flight.
  task automatic set_window(input logic [63:0] base, input logic q);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= base;
    quiet_mode <= q;
    window_base = base;
    n_bases++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic run_random_phase(input logic [63:0] base, input logic q);
    int unsigned start;
    set_window(base, q);
    start = access_backlog.size();
    while (access_backlog.size() - start < PhaseItems) begin
      case ($urandom_range(0, 9))
        0: queue_bar_sizing();
        1: begin
          queue_access(REQ_WRITE, cfg_off(16'h0, REG_COMMAND, 2'd0), SIZE_2B, 64'h0);
          queue_access(REQ_WRITE, cfg_off(16'h0, REG_COMMAND, 2'd0), SIZE_2B, 64'h0002);
        end
        default: queue_random_access();
      endcase
    end
  endtask

  initial begin
    shadow_cmd = 16'h0000;
    shadow_bar_lo = 32'h0;
    shadow_bar_hi = 32'h0;
    shadow_irq_line = IRQ_LINE_RESET;
    shadow_mapped = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: identity reads at odd offsets and widths, read-only and
    // writable dwords, a full map/unmap cycle and absent functions.
    set_window(64'h0, 1'b0);
    queue_access(REQ_READ, cfg_off(16'h0, REG_ID, 2'd0), SIZE_4B, 64'h0);
    queue_access(REQ_READ, cfg_off(16'h0, REG_ID, 2'd0), SIZE_8B, 64'h0);
    queue_access(REQ_READ, cfg_off(16'h0, REG_ID, 2'd2), SIZE_2B, 64'h0);
    queue_access(REQ_READ, cfg_off(16'h0, REG_ID, 2'd3), SIZE_4B, 64'h0);
    queue_access(REQ_READ, cfg_off(16'h0, REG_CLASS_REV, 2'd1), SIZE_1B, 64'h0);
    queue_access(REQ_READ, cfg_off(16'h0, REG_SUBSYS, 2'd0), SIZE_4B, 64'h0);
    queue_access(REQ_READ, cfg_off(16'h0, REG_INTR, 2'd0), SIZE_2B, 64'h0);
    queue_access(REQ_READ, cfg_off(16'h0, REG_BAR0_LO, 2'd0), SIZE_4B, 64'h0);
    queue_access(REQ_WRITE, cfg_off(16'h0, REG_INTR, 2'd0), SIZE_1B, 64'h0B);
    queue_access(REQ_READ, cfg_off(16'h0, REG_INTR, 2'd0), SIZE_4B, 64'h0);
    queue_access(REQ_WRITE, cfg_off(16'h0, REG_ID, 2'd0), SIZE_4B, '1);
    queue_access(REQ_READ, cfg_off(16'h0, REG_ID, 2'd0), SIZE_4B, 64'h0);
    queue_access(REQ_WRITE, cfg_off(16'h0, REG_BAR0_LO, 2'd0), SIZE_4B, 64'hFFFF_FFFF);
    queue_access(REQ_READ, cfg_off(16'h0, REG_BAR0_LO, 2'd0), SIZE_4B, 64'h0);
    queue_access(REQ_WRITE, cfg_off(16'h0, REG_BAR0_LO, 2'd0), SIZE_4B, 64'hAB00_0000);
    queue_access(REQ_WRITE, cfg_off(16'h0, REG_BAR0_HI, 2'd0), SIZE_4B, 64'h1);
    queue_access(REQ_WRITE, cfg_off(16'h0, REG_COMMAND, 2'd0), SIZE_2B, 64'h0006);
    queue_access(REQ_WRITE, cfg_off(16'h0, REG_COMMAND, 2'd1), SIZE_1B, 64'hFF);
    queue_access(REQ_WRITE, cfg_off(16'h0, REG_BAR0_HI, 2'd3), SIZE_2B, 64'hBEEF);
    queue_access(REQ_WRITE, cfg_off(16'h0, REG_BAR0_LO, 2'd2), SIZE_8B, '1);
    // High dword cleared leaves exactly the sizing pattern, which must unmap.
    queue_access(REQ_WRITE, cfg_off(16'h0, REG_BAR0_HI, 2'd0), SIZE_4B, 64'h0);
    queue_access(REQ_READ, cfg_off(16'h0100, REG_ID, 2'd0), SIZE_4B, 64'h0);
    queue_access(REQ_WRITE, cfg_off(16'h0008, REG_COMMAND, 2'd0), SIZE_4B, '1);
    queue_access(REQ_READ, cfg_off(16'h0001, REG_COMMAND, 2'd0), SIZE_2B, 64'h0);
    queue_access(REQ_READ, '1, SIZE_8B, 64'h0);
    queue_access(REQ_READ, cfg_off(16'h0, 10'h3FF, 2'd1), SIZE_4B, 64'h0);

    // Random part under several window bases, the extremes among them.
    run_random_phase('1, 1'b0);
    run_random_phase({$urandom, $urandom}, 1'b1);
    run_random_phase(64'hE000_0000, 1'b0);
    run_random_phase({$urandom, $urandom}, 1'b0);
    run_random_phase(64'h0, 1'b1);

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (due_completions.size() != 0)
      flag_error($sformatf("%0d completions never arrived", due_completions.size()));
    $display("Covered %0d reads and %0d writes (%0d to absent functions) under %0d bases,",
             n_reads, n_writes, n_absent, n_bases);
    $display("with %0d BAR0 map and %0d unmap events; %0d completions checked, %0d errors.",
             n_maps, n_unmaps, n_completed, n_errors);
    if (n_errors == 0) begin
      $display("pcie_type0_config_space_test: done, clean");
    end else begin
      $display("pcie_type0_config_space_test: done, errors");
    end
    $finish;
  end

endmodule
